// ----- hdl/gjre_pkg.sv -----
// ----------------------------------------------------------------------------
// gjre_pkg
// Shared types and constants of the gamepad to joystick report/event block.
// ----------------------------------------------------------------------------
package gjre_pkg;

    // Joystick slots with stored state
    localparam int NUM_STICKS = 16;
    localparam int STK_IW     = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration register width and bus
    localparam int CFG_W   = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CHANGED   = 2'd1;
    localparam logic [1:0] REG_CAPTURE   = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_REPORT = 3'd0;
    localparam logic [2:0] KIND_MOVE   = 3'd1;
    localparam logic [2:0] KIND_ZMOVE  = 3'd2;
    localparam logic [2:0] KIND_BDOWN  = 3'd3;
    localparam logic [2:0] KIND_BUP    = 3'd4;

    // Number of result kinds, one pending bit each
    localparam int NKINDS = 5;

    // Classified request handed from front to back
    typedef struct packed {
        logic        ok;
        logic [3:0]  joystick;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] pov;
        logic [9:0]  buttons;
        logic [3:0]  button_count;
    } t_item;

    // Configuration seen by the back part
    typedef struct packed {
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] chg_mask;
        logic [CFG_W-1:0] cap_mask;
    } t_cfg;

endpackage

// ----- hdl/gamepad_to_joystick_report_events.sv -----
// ----------------------------------------------------------------------------
// gamepad_to_joystick_report_events
// Maps gamepad samples to legacy joystick reports and capture events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one gamepad sample per request.
//   Output channel (o_valid/i_ready) gives one result per request: always a
//   report, then for a captured joystick move, z move, button down and
//   button up events as they apply; o_last marks the final one.
//   Throughput: one result per cycle while i_ready stays high, issued from
//   the single output register of the back part.
//   A two-entry queue sits between the front (mapping, POV squares) and the
//   back (event decisions, stored last values), so samples keep coming in
//   while results wait.
//   Configuration goes through the APB port; write only while idle.
//   Clearing a capture bit zeroes that joystick's stored values.
//   Reset clears registers, stored values and all in-flight requests.
//   When the receiver stalls, the current result holds and the queue fills,
//   then o_ready drops.
// ----------------------------------------------------------------------------
module gamepad_to_joystick_report_events (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gjre_pkg::PADDR_W-1:0] paddr,
    input  logic [gjre_pkg::PDATA_W-1:0] pwdata,
    output logic [gjre_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [3:0]                   i_joystick,
    input  logic                         i_connected,
    input  logic [3:0]                   i_dpad,
    input  logic signed [15:0]           i_stick_left_x,
    input  logic signed [15:0]           i_stick_left_y,
    input  logic [14:0]                  i_trigger_left,
    input  logic [14:0]                  i_trigger_right,
    input  logic signed [15:0]           i_stick_right_x,
    input  logic signed [15:0]           i_stick_right_y,
    input  logic [10:0]                  i_raw_buttons,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2:0]                   o_kind,
    output logic [3:0]                   o_stick_index,
    output logic [15:0]                  o_pos_x,
    output logic [15:0]                  o_pos_y,
    output logic [15:0]                  o_pos_z,
    output logic [15:0]                  o_pov,
    output logic [9:0]                   o_buttons,
    output logic [3:0]                   o_button_count,
    output logic [17:0]                  o_event_data,
    output logic                         o_status,
    output logic                         o_last
);
    import gjre_pkg::*;

    t_cfg             r_cfg;
    logic             wr;
    logic [1:0]       reg_idx;
    logic [CFG_W-1:0] clr;
    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;
    t_item            f_item;
    t_item            q_item;

    // Register access
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign clr     = (wr && (reg_idx == REG_CAPTURE)) ?
                     (r_cfg.cap_mask & ~pwdata[CFG_W-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            unique case (reg_idx)
                REG_THRESHOLD: r_cfg.thr      <= pwdata[CFG_W-1:0];
                REG_CHANGED:   r_cfg.chg_mask <= pwdata[CFG_W-1:0];
                REG_CAPTURE:   r_cfg.cap_mask <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = PDATA_W'(r_cfg.thr);
            REG_CHANGED:   prdata = PDATA_W'(r_cfg.chg_mask);
            REG_CAPTURE:   prdata = PDATA_W'(r_cfg.cap_mask);
            default:       prdata = '0;
        endcase
    end

    // Front: accept and classify
    gjre_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_joystick      (i_joystick),
        .i_connected     (i_connected),
        .i_dpad          (i_dpad),
        .i_stick_left_x  (i_stick_left_x),
        .i_stick_left_y  (i_stick_left_y),
        .i_trigger_left  (i_trigger_left),
        .i_trigger_right (i_trigger_right),
        .i_stick_right_x (i_stick_right_x),
        .i_stick_right_y (i_stick_right_y),
        .i_raw_buttons   (i_raw_buttons),
        .o_push          (push),
        .i_q_ready       (q_ready),
        .o_item          (f_item)
    );

    // Queue between the two parts
    gjre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    // Back: events, stored values, results
    gjre_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_ready      (pop),
        .i_item         (q_item),
        .i_cfg          (r_cfg),
        .i_clr          (clr),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_stick_index  (o_stick_index),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_pov          (o_pov),
        .o_buttons      (o_buttons),
        .o_button_count (o_button_count),
        .o_event_data   (o_event_data),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    // An unplugged joystick yields a single report
    a_unplugged_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && (o_kind == KIND_REPORT))
        else $error("unplugged result is not a lone report");

    // Events only for plugged joysticks
    a_event_plugged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_REPORT) |-> !o_status)
        else $error("event issued for unplugged joystick");

    // Button count agrees with the mapped buttons
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_button_count) == $countones(o_buttons)))
        else $error("button count mismatch");

    // A result after a final one must be a report
    a_report_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last ##1 o_valid |-> (o_kind == KIND_REPORT))
        else $error("new sample did not start with a report");

endmodule

// ----- hdl/gjre_front.sv -----
// ----------------------------------------------------------------------------
// gjre_front
// Accepts gamepad samples, squares the right stick, then maps axes, triggers,
// POV and buttons into one classified request for the queue.
// ----------------------------------------------------------------------------
module gjre_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_joystick,
    input  logic               i_connected,
    input  logic [3:0]         i_dpad,
    input  logic signed [15:0] i_stick_left_x,
    input  logic signed [15:0] i_stick_left_y,
    input  logic [14:0]        i_trigger_left,
    input  logic [14:0]        i_trigger_right,
    input  logic signed [15:0] i_stick_right_x,
    input  logic signed [15:0] i_stick_right_y,
    input  logic [10:0]        i_raw_buttons,
    output logic               o_push,
    input  logic               i_q_ready,
    output gjre_pkg::t_item    o_item
);
    import gjre_pkg::*;

    localparam logic [32:0] POV_MAG_MIN = 33'd64000000;

    logic               r_valid;
    logic [3:0]         r_joy;
    logic               r_conn;
    logic [3:0]         r_dpad;
    logic [15:0]        r_lx;
    logic [15:0]        r_ly;
    logic [14:0]        r_tl;
    logic [14:0]        r_tr;
    logic signed [15:0] r_rx;
    logic signed [15:0] r_ry;
    logic [10:0]        r_raw;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;

    logic signed [31:0] sqx;
    logic signed [31:0] sqy;
    logic [32:0]        mag;
    logic               ok;
    logic               xh, xl, xs, yh, yl, ys;
    logic [15:0]        px, py, pz, pov;
    logic [9:0]         btn;
    logic [3:0]         cnt;

    // Map one axis: d-pad overrides the stick, opposite directions cancel
    function automatic logic [15:0] map_axis(input logic neg, input logic pos,
                                             input logic other,
                                             input logic [15:0] stick);
        logic [15:0] res;
        priority if (neg && pos)   res = 16'h8000;
        else if (neg && other)     res = 16'h2000;
        else if (pos && other)     res = 16'hDFFF;
        else if (neg)              res = 16'h0000;
        else if (pos)              res = 16'hFFFF;
        else                       res = {~stick[15], stick[14:0]};
        return res;
    endfunction

    // Advance when the stage is empty or its request moves on
    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;

    assign sqx = i_stick_right_x * i_stick_right_x;
    assign sqy = i_stick_right_y * i_stick_right_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the sample and the squares of the right stick
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_joy  <= i_joystick;
            r_conn <= i_connected;
            r_dpad <= i_dpad;
            r_lx   <= i_stick_left_x;
            r_ly   <= i_stick_left_y;
            r_tl   <= i_trigger_left;
            r_tr   <= i_trigger_right;
            r_rx   <= i_stick_right_x;
            r_ry   <= i_stick_right_y;
            r_raw  <= i_raw_buttons;
            r_sqx  <= sqx;
            r_sqy  <= sqy;
        end
    end

    // Classify the sample
    always_comb begin
        ok  = r_conn && (r_joy <= 4'(NUM_STICKS - 1));
        px  = map_axis(r_dpad[0], r_dpad[1], r_dpad[2] || r_dpad[3], r_lx);
        py  = map_axis(r_dpad[2], r_dpad[3], r_dpad[0] || r_dpad[1], r_ly);
        pz  = 16'h8000 + {1'b0, r_tr} - {1'b0, r_tl};
        mag = {1'b0, r_sqx} + {1'b0, r_sqy};
        xh  = r_rx >= 16'sd16384;
        xl  = r_rx <= -16'sd16384;
        xs  = !xh && !xl;
        yh  = r_ry >= 16'sd16384;
        yl  = r_ry <= -16'sd16384;
        ys  = !yh && !yl;
        priority if (mag < POV_MAG_MIN) pov = 16'hFFFF;
        else if (xh && ys)              pov = 16'h2328;
        else if (xl && ys)              pov = 16'h6978;
        else if (yh && xs)              pov = 16'h4650;
        else if (yl && xs)              pov = 16'h0000;
        else if (xh && yh)              pov = 16'h34BC;
        else if (xh && yl)              pov = 16'h1194;
        else if (xl && yh)              pov = 16'h57E4;
        else if (xl && yl)              pov = 16'h7B0C;
        else                            pov = 16'hFFFF;
        // touchpad shares bit 6 with back
        btn = r_raw[9:0] | {3'b000, r_raw[10], 6'b000000};
        cnt = '0;
        for (int k = 0; k < 10; k++) begin
            cnt = cnt + 4'(btn[k]);
        end
    end

    // Unplugged samples carry only the index
    always_comb begin
        o_item          = '0;
        o_item.ok       = ok;
        o_item.joystick = r_joy;
        if (ok) begin
            o_item.pos_x        = px;
            o_item.pos_y        = py;
            o_item.pos_z        = pz;
            o_item.pov          = pov;
            o_item.buttons      = btn;
            o_item.button_count = cnt;
        end
    end

endmodule

// ----- hdl/gjre_queue.sv -----
// ----------------------------------------------------------------------------
// gjre_queue
// Short first-in first-out queue of classified requests between front and
// back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module gjre_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  gjre_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output gjre_pkg::t_item o_item
);
    import gjre_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           wr;
    logic           rd;

    assign o_ready = r_cnt != QCW'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign wr      = i_push && o_ready;
    assign rd      = i_pop && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- hdl/gjre_back.sv -----
// ----------------------------------------------------------------------------
// gjre_back
// Takes classified requests, decides the events against the stored last
// values, updates them and issues one result per cycle, while the receiver
// takes them, through an output register.
// ----------------------------------------------------------------------------
module gjre_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_ready,
    input  gjre_pkg::t_item            i_item,
    input  gjre_pkg::t_cfg             i_cfg,
    input  logic [gjre_pkg::CFG_W-1:0] i_clr,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_kind,
    output logic [3:0]                 o_stick_index,
    output logic [15:0]                o_pos_x,
    output logic [15:0]                o_pos_y,
    output logic [15:0]                o_pos_z,
    output logic [15:0]                o_pov,
    output logic [9:0]                 o_buttons,
    output logic [3:0]                 o_button_count,
    output logic [17:0]                o_event_data,
    output logic                       o_status,
    output logic                       o_last
);
    import gjre_pkg::*;

    logic [15:0]       r_last_x [NUM_STICKS];
    logic [15:0]       r_last_y [NUM_STICKS];
    logic [15:0]       r_last_z [NUM_STICKS];
    logic [9:0]        r_last_b [NUM_STICKS];

    t_item             r_cur;
    logic [NKINDS-1:0] r_pend;
    logic [17:0]       r_dn_data;
    logic [17:0]       r_up_data;

    logic [STK_IW-1:0] idx;
    logic [15:0]       lx, ly, lz;
    logic [9:0]        lb, bc;
    logic              cap, chg, mv, zv, dn, up;
    logic [NKINDS-1:0] n_pend;
    logic [NKINDS-1:0] sel;
    logic [NKINDS-1:0] rest;
    logic [NKINDS-1:0] pend_after;
    logic              out_free;
    logic              fire;
    logic              load;
    logic [2:0]        kind;
    logic [17:0]       edata;

    function automatic logic [15:0] adiff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Decide the events of the request at the queue head
    always_comb begin
        idx = i_item.joystick[STK_IW-1:0];
        lx  = r_last_x[idx];
        ly  = r_last_y[idx];
        lz  = r_last_z[idx];
        lb  = r_last_b[idx];
        cap = i_item.ok && i_cfg.cap_mask[i_item.joystick];
        chg = i_cfg.chg_mask[i_item.joystick];
        mv  = !chg || (adiff(lx, i_item.pos_x) > i_cfg.thr)
                   || (adiff(ly, i_item.pos_y) > i_cfg.thr);
        zv  = !chg || (adiff(lz, i_item.pos_z) > i_cfg.thr);
        bc  = lb ^ i_item.buttons;
        dn  = |(i_item.buttons & bc);
        up  = |(lb & bc);
        n_pend = {cap && up, cap && dn, cap && zv, cap && mv, 1'b1};
    end

    // Issue the lowest pending result when the output register frees up
    always_comb begin
        out_free   = !o_valid || i_ready;
        fire       = out_free && (r_pend != '0);
        sel        = r_pend & (~r_pend + 1'b1);
        rest       = r_pend & ~sel;
        pend_after = fire ? rest : r_pend;
        o_q_ready  = pend_after == '0;
        load       = i_q_valid && o_q_ready;
        priority if (sel[0]) kind = KIND_REPORT;
        else if (sel[1])     kind = KIND_MOVE;
        else if (sel[2])     kind = KIND_ZMOVE;
        else if (sel[3])     kind = KIND_BDOWN;
        else                 kind = KIND_BUP;
        unique case (kind)
            KIND_BDOWN: edata = r_dn_data;
            KIND_BUP:   edata = r_up_data;
            default:    edata = {8'b0, r_cur.buttons};
        endcase
    end

    // Track pending results and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_pend <= load ? n_pend : pend_after;
            if (fire) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Hold the current request
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur     <= i_item;
            r_dn_data <= {bc, 8'b0} | {8'b0, i_item.buttons & bc};
            r_up_data <= {bc, 8'b0} | {8'b0, lb & bc};
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_kind         <= kind;
            o_stick_index  <= r_cur.joystick;
            o_pos_x        <= r_cur.pos_x;
            o_pos_y        <= r_cur.pos_y;
            o_pos_z        <= r_cur.pos_z;
            o_pov          <= r_cur.pov;
            o_buttons      <= r_cur.buttons;
            o_button_count <= r_cur.button_count;
            o_event_data   <= edata;
            o_status       <= !r_cur.ok;
            o_last         <= rest == '0;
        end
    end

    // Clear on release of capture, else update on the events taken
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_STICKS; j++) begin
            if (!i_rst_n || i_clr[j]) begin
                r_last_x[j] <= '0;
                r_last_y[j] <= '0;
                r_last_z[j] <= '0;
                r_last_b[j] <= '0;
            end else if (load && cap && (idx == STK_IW'(j))) begin
                if (mv) begin
                    r_last_x[j] <= i_item.pos_x;
                    r_last_y[j] <= i_item.pos_y;
                end
                if (zv) begin
                    r_last_z[j] <= i_item.pos_z;
                end
                if (bc != '0) begin
                    r_last_b[j] <= i_item.buttons;
                end
            end
        end
    end

endmodule

// ----- bench/joystick_result_checker.sv -----
// ----------------------------------------------------------------------------
// joystick_result_checker
// Watches the APB port and both request channels of the gamepad to joystick
// block. Keeps its own copy of the registers and of the stored per-joystick
// values, works out the report and events of every accepted sample, and
// compares each result field by field against the oldest one outstanding.
// ----------------------------------------------------------------------------
module joystick_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gjre_pkg::PADDR_W-1:0] paddr,
    input  logic [gjre_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    input  logic                         i_smp_valid,
    input  logic                         i_smp_ready,
    input  logic [3:0]                   i_joystick,
    input  logic                         i_connected,
    input  logic [3:0]                   i_dpad,
    input  logic signed [15:0]           i_stick_left_x,
    input  logic signed [15:0]           i_stick_left_y,
    input  logic [14:0]                  i_trigger_left,
    input  logic [14:0]                  i_trigger_right,
    input  logic signed [15:0]           i_stick_right_x,
    input  logic signed [15:0]           i_stick_right_y,
    input  logic [10:0]                  i_raw_buttons,
    input  logic                         i_res_valid,
    input  logic                         i_res_ready,
    input  logic [2:0]                   i_kind,
    input  logic [3:0]                   i_stick_index,
    input  logic [15:0]                  i_pos_x,
    input  logic [15:0]                  i_pos_y,
    input  logic [15:0]                  i_pos_z,
    input  logic [15:0]                  i_pov,
    input  logic [9:0]                   i_buttons,
    input  logic [3:0]                   i_button_count,
    input  logic [17:0]                  i_event_data,
    input  logic                         i_status,
    input  logic                         i_last,
    output int                           o_mismatches,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gjre_pkg::*;

    localparam logic [15:0] AXIS_CENTER    = 16'h8000;
    localparam logic [15:0] AXIS_NEG_DIAG  = 16'h2000;
    localparam logic [15:0] AXIS_POS_DIAG  = 16'hDFFF;
    localparam logic [15:0] AXIS_MIN       = 16'h0000;
    localparam logic [15:0] AXIS_MAX       = 16'hFFFF;
    localparam logic [15:0] POV_CENTERED   = 16'hFFFF;
    localparam logic [15:0] POV_UP         = 16'h0000;
    localparam logic [15:0] POV_UP_RIGHT   = 16'h1194;
    localparam logic [15:0] POV_RIGHT      = 16'h2328;
    localparam logic [15:0] POV_DOWN_RIGHT = 16'h34BC;
    localparam logic [15:0] POV_DOWN       = 16'h4650;
    localparam logic [15:0] POV_DOWN_LEFT  = 16'h57E4;
    localparam logic [15:0] POV_LEFT       = 16'h6978;
    localparam logic [15:0] POV_UP_LEFT    = 16'h7B0C;
    localparam longint      POV_DEAD_SQ    = 64000000;
    localparam int          POV_HALF       = 16384;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  stick_index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] pov;
        logic [9:0]  buttons;
        logic [3:0]  button_count;
        logic [17:0] event_data;
        logic        status;
        logic        last;
    } t_joy_result;

    // Register copies and stored per-joystick values
    logic [15:0] cfg_threshold;
    logic [15:0] cfg_changed;
    logic [15:0] cfg_capture;
    logic [15:0] stored_x [16];
    logic [15:0] stored_y [16];
    logic [15:0] stored_z [16];
    logic [9:0]  stored_btn [16];

    t_joy_result expected_results [$];
    int          mismatch_count;
    int          result_count;

    function automatic logic [15:0] axis_position(input logic neg, input logic pos,
                                                  input logic other,
                                                  input logic [15:0] stick);
        if (neg && pos) return AXIS_CENTER;
        if (neg && other) return AXIS_NEG_DIAG;
        if (pos && other) return AXIS_POS_DIAG;
        if (neg) return AXIS_MIN;
        if (pos) return AXIS_MAX;
        return stick ^ AXIS_CENTER;
    endfunction

    function automatic logic [15:0] pov_direction(input logic signed [15:0] x,
                                                  input logic signed [15:0] y);
        longint mag;
        logic   xh, xl, xs, yh, yl, ys;
        mag = longint'(x) * longint'(x) + longint'(y) * longint'(y);
        xh = (x >= POV_HALF);
        xl = (x <= -POV_HALF);
        xs = !xh && !xl;
        yh = (y >= POV_HALF);
        yl = (y <= -POV_HALF);
        ys = !yh && !yl;
        if (mag < POV_DEAD_SQ) return POV_CENTERED;
        if (xh && ys) return POV_RIGHT;
        if (xl && ys) return POV_LEFT;
        if (yh && xs) return POV_DOWN;
        if (yl && xs) return POV_UP;
        if (xh && yh) return POV_DOWN_RIGHT;
        if (xh && yl) return POV_UP_RIGHT;
        if (xl && yh) return POV_DOWN_LEFT;
        if (xl && yl) return POV_UP_LEFT;
        return POV_CENTERED;
    endfunction

    function automatic logic [15:0] axis_distance(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic clear_stick(input int j);
        stored_x[j]   = '0;
        stored_y[j]   = '0;
        stored_z[j]   = '0;
        stored_btn[j] = '0;
    endtask

    // Mirror a register write; dropping a capture bit wipes that joystick
    task automatic apply_register_write(input logic [1:0] idx, input logic [15:0] value);
        case (idx)
            REG_THRESHOLD: begin
                cfg_threshold = value;
            end
            REG_CHANGED: begin
                cfg_changed = value;
            end
            REG_CAPTURE: begin
                for (int j = 0; j < 16; j++)
                    if (cfg_capture[j] && !value[j]) clear_stick(j);
                cfg_capture = value;
            end
            default: begin
            end
        endcase
    endtask

    // Work out the report and events of one accepted sample
    task automatic predict_joystick_results();
        t_joy_result batch [5];
        t_joy_result r;
        int          n;
        int          j;
        logic        chg;
        logic [15:0] px, py, pz;
        logic [9:0]  btn, flips;

        j = i_joystick;
        r = '0;
        n = 0;
        r.stick_index = i_joystick;
        if (!i_connected) begin
            r.status = 1'b1;
            r.last   = 1'b1;
            expected_results.push_back(r);
            return;
        end

        px = axis_position(i_dpad[0], i_dpad[1], i_dpad[2] || i_dpad[3], i_stick_left_x);
        py = axis_position(i_dpad[2], i_dpad[3], i_dpad[0] || i_dpad[1], i_stick_left_y);
        pz = 16'h8000 + {1'b0, i_trigger_right} - {1'b0, i_trigger_left};
        btn = i_raw_buttons[9:0] | (10'(i_raw_buttons[10]) << 6);

        r.pos_x        = px;
        r.pos_y        = py;
        r.pos_z        = pz;
        r.pov          = pov_direction(i_stick_right_x, i_stick_right_y);
        r.buttons      = btn;
        r.button_count = 4'($countones(btn));
        r.event_data   = {8'b0, btn};
        r.kind         = KIND_REPORT;
        batch[n] = r;
        n++;

        if (cfg_capture[j]) begin
            chg = cfg_changed[j];
            if (!chg || axis_distance(stored_x[j], px) > cfg_threshold
                     || axis_distance(stored_y[j], py) > cfg_threshold) begin
                r.kind = KIND_MOVE;
                batch[n] = r;
                n++;
                stored_x[j] = px;
                stored_y[j] = py;
            end
            if (!chg || axis_distance(stored_z[j], pz) > cfg_threshold) begin
                r.kind = KIND_ZMOVE;
                batch[n] = r;
                n++;
                stored_z[j] = pz;
            end
            flips = stored_btn[j] ^ btn;
            if (flips != '0) begin
                // changed bits sit 8 up and overlap the affected bits
                if ((btn & flips) != '0) begin
                    r.kind       = KIND_BDOWN;
                    r.event_data = {flips, 8'b0} | {8'b0, btn & flips};
                    batch[n] = r;
                    n++;
                end
                if ((stored_btn[j] & flips) != '0) begin
                    r.kind       = KIND_BUP;
                    r.event_data = {flips, 8'b0} | {8'b0, stored_btn[j] & flips};
                    batch[n] = r;
                    n++;
                end
                stored_btn[j] = btn;
            end
        end

        batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_results.push_back(batch[k]);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR t=%0t result %0d: %s", $realtime, result_count, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [17:0] got,
                                 input logic [17:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Compare one accepted result with the oldest outstanding one
    task automatic check_result();
        t_joy_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d stick %0d",
                                      i_kind, i_stick_index));
        end else begin
            want = expected_results.pop_front();
            compare_field("kind", 18'(i_kind), 18'(want.kind));
            compare_field("stick_index", 18'(i_stick_index), 18'(want.stick_index));
            compare_field("pos_x", 18'(i_pos_x), 18'(want.pos_x));
            compare_field("pos_y", 18'(i_pos_y), 18'(want.pos_y));
            compare_field("pos_z", 18'(i_pos_z), 18'(want.pos_z));
            compare_field("pov", 18'(i_pov), 18'(want.pov));
            compare_field("buttons", 18'(i_buttons), 18'(want.buttons));
            compare_field("button_count", 18'(i_button_count), 18'(want.button_count));
            compare_field("event_data", i_event_data, want.event_data);
            compare_field("status", 18'(i_status), 18'(want.status));
            compare_field("last", 18'(i_last), 18'(want.last));
        end
        result_count++;
    endtask

    // Track config, predict on sample accept, check on result accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_threshold = '0;
            cfg_changed   = '0;
            cfg_capture   = '0;
            for (int j = 0; j < 16; j++) clear_stick(j);
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                apply_register_write(paddr[PADDR_W-1:2], pwdata[15:0]);
            if (i_smp_valid && i_smp_ready) predict_joystick_results();
            if (i_res_valid && i_res_ready) check_result();
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives gamepad samples and register writes into the gamepad to joystick
// block: a directed pass over axis, POV, trigger and button corners, then
// random samples under several register settings with random gaps and
// stalls on both channels. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gjre_pkg::*;

    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam logic [3:0]  DPAD_LEFT    = 4'b0001;
    localparam logic [3:0]  DPAD_RIGHT   = 4'b0010;
    localparam logic [3:0]  DPAD_UP      = 4'b0100;
    localparam logic [3:0]  DPAD_DOWN    = 4'b1000;
    localparam logic [10:0] BTN_BACK     = 11'h040;
    localparam logic [10:0] BTN_TOUCHPAD = 11'h400;
    localparam logic [10:0] BTN_ALL      = 11'h7FF;
    localparam logic [15:0] S_MIN        = 16'h8000;
    localparam logic [15:0] S_MAX        = 16'h7FFF;
    localparam logic [14:0] T_MAX        = 15'h7FFF;
    localparam int          PHASE_ITEMS  = 73;
    localparam int          NUM_PHASES   = 6;
    localparam int          CYCLE_LIMIT  = 200000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [PADDR_W-1:0]           paddr;
    logic [PDATA_W-1:0]           pwdata;
    logic [PDATA_W-1:0]           prdata;
    logic                         pready;
    logic                         i_valid;
    logic                         o_ready;
    logic [3:0]                   i_joystick;
    logic                         i_connected;
    logic [3:0]                   i_dpad;
    logic signed [15:0]           i_stick_left_x;
    logic signed [15:0]           i_stick_left_y;
    logic [14:0]                  i_trigger_left;
    logic [14:0]                  i_trigger_right;
    logic signed [15:0]           i_stick_right_x;
    logic signed [15:0]           i_stick_right_y;
    logic [10:0]                  i_raw_buttons;
    logic                         o_valid;
    logic                         i_ready;
    logic [2:0]                   o_kind;
    logic [3:0]                   o_stick_index;
    logic [15:0]                  o_pos_x;
    logic [15:0]                  o_pos_y;
    logic [15:0]                  o_pos_z;
    logic [15:0]                  o_pov;
    logic [9:0]                   o_buttons;
    logic [3:0]                   o_button_count;
    logic [17:0]                  o_event_data;
    logic                         o_status;
    logic                         o_last;

    int          mismatches;
    int          pending;
    int          cycle_count;
    logic        gaps_on;
    logic [10:0] prev_raw [16];

    gamepad_to_joystick_report_events uut (.*);

    joystick_result_checker joy_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .i_smp_valid     (i_valid),
        .i_smp_ready     (o_ready),
        .i_joystick      (i_joystick),
        .i_connected     (i_connected),
        .i_dpad          (i_dpad),
        .i_stick_left_x  (i_stick_left_x),
        .i_stick_left_y  (i_stick_left_y),
        .i_trigger_left  (i_trigger_left),
        .i_trigger_right (i_trigger_right),
        .i_stick_right_x (i_stick_right_x),
        .i_stick_right_y (i_stick_right_y),
        .i_raw_buttons   (i_raw_buttons),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_kind          (o_kind),
        .i_stick_index   (o_stick_index),
        .i_pos_x         (o_pos_x),
        .i_pos_y         (o_pos_y),
        .i_pos_z         (o_pos_z),
        .i_pov           (o_pov),
        .i_buttons       (o_buttons),
        .i_button_count  (o_button_count),
        .i_event_data    (o_event_data),
        .i_status        (o_status),
        .i_last          (o_last),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // Generate clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    // Write one register: setup cycle, then access until pready
    task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one request and hold it until accepted; entered at a falling edge
    task automatic send_sample(input logic [3:0] js, input logic conn, input logic [3:0] dp,
                               input logic [15:0] lx, input logic [15:0] ly,
                               input logic [14:0] tl, input logic [14:0] tr,
                               input logic [15:0] rx, input logic [15:0] ry,
                               input logic [10:0] raw);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_joystick      = js;
        i_connected     = conn;
        i_dpad          = dp;
        i_stick_left_x  = lx;
        i_stick_left_y  = ly;
        i_trigger_left  = tl;
        i_trigger_right = tr;
        i_stick_right_x = rx;
        i_stick_right_y = ry;
        i_raw_buttons   = raw;
        i_valid         = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every outstanding result is back
    task automatic wait_results_drained();
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return S_MIN;
            1: return S_MAX;
            2: return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_trigger();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return T_MAX;
            default: return 15'($urandom);
        endcase
    endfunction

    // Random sample; bias toward a few joysticks so stored values matter
    task automatic send_random_sample();
        logic [3:0]  js;
        logic [10:0] raw;
        js = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        case ($urandom_range(0, 5))
            0: raw = '0;
            1: raw = BTN_ALL;
            2, 3: raw = 11'($urandom);
            4: raw = prev_raw[js];
            default: raw = prev_raw[js] ^ (11'd1 << $urandom_range(0, 10));
        endcase
        prev_raw[js] = raw;
        send_sample(js, $urandom_range(0, 9) != 0,
                    $urandom_range(0, 1) ? 4'($urandom) : 4'd0,
                    pick_axis(), pick_axis(), pick_trigger(), pick_trigger(),
                    pick_axis(), pick_axis(), raw);
    endtask

    initial begin
        logic [15:0] thr_val, chg_val, cap_val;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_valid         = 1'b0;
        i_joystick      = '0;
        i_connected     = 1'b0;
        i_dpad          = '0;
        i_stick_left_x  = '0;
        i_stick_left_y  = '0;
        i_trigger_left  = '0;
        i_trigger_right = '0;
        i_stick_right_x = '0;
        i_stick_right_y = '0;
        i_raw_buttons   = '0;
        gaps_on         = 1'b1;
        for (int j = 0; j < 16; j++) prev_raw[j] = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners with every joystick captured
        apb_write(REG_CAPTURE, 16'hFFFF);
        send_sample(4'd5, 1'b0, 4'hF, S_MAX, S_MIN, T_MAX, T_MAX, S_MAX, S_MAX, BTN_ALL);
        send_sample(4'd0, 1'b1, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 16'd0, 11'd0);
        send_sample(4'd0, 1'b1, DPAD_LEFT, S_MIN, S_MAX, T_MAX, 15'd0,
                    S_MAX, 16'd0, 11'h001);
        send_sample(4'd0, 1'b1, DPAD_RIGHT, S_MAX, S_MIN, 15'd0, T_MAX,
                    S_MIN, 16'd0, 11'h002);
        send_sample(4'd1, 1'b1, DPAD_UP, 16'd0, S_MAX, 15'd1, 15'd2, 16'd0, S_MAX, 11'h004);
        send_sample(4'd1, 1'b1, DPAD_DOWN, 16'd0, S_MIN, 15'd2, 15'd1, 16'd0, S_MIN, 11'h008);
        send_sample(4'd2, 1'b1, DPAD_LEFT | DPAD_RIGHT | DPAD_UP, S_MIN, S_MIN, 15'd0, 15'd0,
                    S_MAX, S_MAX, 11'h010);
        send_sample(4'd2, 1'b1, DPAD_RIGHT | DPAD_DOWN, S_MAX, S_MAX, 15'd0, 15'd0,
                    S_MAX, S_MIN, 11'h020);
        send_sample(4'd2, 1'b1, DPAD_LEFT | DPAD_UP, 16'd5, 16'd5, 15'd0, 15'd0,
                    S_MIN, S_MAX, 11'h080);
        send_sample(4'd3, 1'b1, 4'hF, 16'd9, 16'd9, 15'd0, 15'd0, S_MIN, S_MIN, 11'h100);
        send_sample(4'd3, 1'b1, DPAD_UP | DPAD_DOWN, S_MAX, 16'd0, 15'd0, 15'd0,
                    16'sd16384, 16'd0, 11'h200);
        send_sample(4'd3, 1'b1, 4'h0, 16'hFFFF, 16'd1, 15'd0, T_MAX,
                    16'sd7999, 16'd0, 11'h200);
        send_sample(4'd4, 1'b1, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0, 16'sd8000, 16'd0, 11'd0);
        send_sample(4'd4, 1'b1, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0,
                    16'sd16383, 16'sd16383, 11'd0);
        send_sample(4'd4, 1'b1, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0,
                    -16'sd16384, 16'sd16383, BTN_TOUCHPAD);
        send_sample(4'd4, 1'b1, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 16'd0,
                    BTN_TOUCHPAD | BTN_BACK);
        send_sample(4'd4, 1'b1, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 16'd0, 11'h3FF);
        send_sample(4'd4, 1'b1, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 16'd0, 11'd0);
        send_sample(4'd15, 1'b1, 4'hF, S_MIN, S_MAX, T_MAX, 15'd0, S_MIN, S_MIN, BTN_ALL);
        send_sample(4'd15, 1'b0, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 16'd0, 11'd0);

        // Changed-only at the widest threshold: no move ever passes
        wait_results_drained();
        apb_write(REG_CHANGED, 16'hFFFF);
        apb_write(REG_THRESHOLD, 16'hFFFF);
        send_sample(4'd0, 1'b1, 4'h0, S_MIN, S_MAX, T_MAX, 15'd0, 16'd0, 16'd0, 11'h055);
        send_sample(4'd0, 1'b1, 4'h0, S_MAX, S_MIN, 15'd0, T_MAX, 16'd0, 16'd0, 11'h2AA);

        // Zero threshold: a repeated sample yields only its report
        wait_results_drained();
        apb_write(REG_THRESHOLD, 16'h0000);
        send_sample(4'd6, 1'b1, 4'h0, 16'd77, 16'd88, 15'd9, 15'd3, 16'd0, 16'd0, 11'h013);
        send_sample(4'd6, 1'b1, 4'h0, 16'd77, 16'd88, 15'd9, 15'd3, 16'd0, 16'd0, 11'h013);

        // Release every joystick, poke the unused address
        wait_results_drained();
        apb_write(REG_CAPTURE, 16'h0000);
        apb_write(REG_UNUSED, 16'($urandom));
        send_sample(4'd6, 1'b1, 4'h0, 16'd1, 16'd2, 15'd3, 15'd4, 16'd0, 16'd0, 11'h013);

        // Random phases under varied settings; the last one runs without gaps
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_results_drained();
            case (phase)
                0: begin
                    thr_val = 16'h0000;
                    chg_val = 16'h0000;
                    cap_val = 16'hFFFF;
                end
                1: begin
                    thr_val = 16'hFFFF;
                    chg_val = 16'hFFFF;
                    cap_val = 16'hFFFF;
                end
                2: begin
                    thr_val = 16'($urandom_range(0, 16'h3000));
                    chg_val = 16'($urandom);
                    cap_val = 16'($urandom);
                end
                3: begin
                    thr_val = 16'($urandom_range(0, 16'h0800));
                    chg_val = 16'hFFFF;
                    cap_val = 16'hFFFF;
                end
                4: begin
                    thr_val = 16'($urandom);
                    chg_val = 16'($urandom);
                    cap_val = 16'h0000;
                end
                default: begin
                    thr_val = 16'($urandom_range(0, 16'h1000));
                    chg_val = 16'($urandom);
                    cap_val = 16'($urandom);
                end
            endcase
            apb_write(REG_THRESHOLD, thr_val);
            apb_write(REG_CHANGED, chg_val);
            apb_write(REG_CAPTURE, cap_val);
            gaps_on = (phase == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) send_random_sample();
        end

        // Drain, let the pipeline settle, then judge
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
